/* rtl/core/fud_pkg.sv */
// Shared types, codes and the CRC-8 byte update for the framed receive deframer.
// No dependencies; imported by fud_frame_ctl and framed_uart_rx_deframer_crc8_unit.
package fud_pkg;

	localparam logic [7:0] SOF_BYTE          = 8'hAA;
	localparam logic [7:0] EOF_BYTE          = 8'h55;
	localparam logic [7:0] CRC_POLY          = 8'h07;
	localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd128;

	typedef enum logic [2:0] {
		KIND_IGNORED = 3'd0,
		KIND_START   = 3'd1,
		KIND_LENGTH  = 3'd2,
		KIND_COMMAND = 3'd3,
		KIND_PAYLOAD = 3'd4,
		KIND_CHECK   = 3'd5,
		KIND_END     = 3'd6
	} byte_kind_t;

	typedef enum logic [2:0] {
		STATUS_NONE     = 3'd0,
		STATUS_GOOD     = 3'd1,
		STATUS_MISMATCH = 3'd2,
		STATUS_BAD_END  = 3'd3,
		STATUS_TOO_LONG = 3'd4
	} frame_status_t;

	typedef struct packed {
		byte_kind_t    kind;
		logic [7:0]    pbyte;
		logic [7:0]    pindex;
		frame_status_t status;
		logic [7:0]    cmd;
		logic [7:0]    len;
	} fud_result_t;

	// CRC-8, MSB first, no reflection, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/framed_uart_rx_deframer_crc8_unit.sv */
// Top level of the framed receive deframer: input register, frame control, result register.
// Depends on fud_pkg and fud_frame_ctl.
//
// Takes one received byte per beat and returns one result beat per byte, in order. Frames are
// 0xAA, length, command, payload, CRC-8 (poly 0x07, init 0) over command and payload, 0x55.
// Throughput is one byte per cycle while out_stall does not hold the result register; each
// byte passes the input register, then the result register. The frame state and CRC update
// between those registers. in_stall rises only when the input register is full and the result
// register is held by out_stall. max_payload is written through cfg_we/cfg_wdata (reset 128);
// a length above it ends the frame at the length byte with a length-too-long status.
module framed_uart_rx_deframer_crc8_unit import fud_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] byte_kind,
	output logic [7:0] payload_byte,
	output logic [7:0] payload_index,
	output logic [2:0] frame_status,
	output logic [7:0] frame_command,
	output logic [7:0] frame_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	fud_result_t res_q;
	fud_result_t res;
	logic [7:0]  max_payload_q;
	logic        advance;
	logic        take_in;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= rx_byte;
		end
	end

	fud_frame_ctl u_ctl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.rx_byte     (byte_s1),
		.max_payload (max_payload_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign byte_kind     = res_q.kind;
	assign payload_byte  = res_q.pbyte;
	assign payload_index = res_q.pindex;
	assign frame_status  = res_q.status;
	assign frame_command = res_q.cmd;
	assign frame_length  = res_q.len;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_index_in_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_kind == KIND_PAYLOAD) |-> (payload_index < frame_length))
		else $error("payload index beyond frame length");

	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status != STATUS_NONE) |->
		(byte_kind == KIND_LENGTH || byte_kind == KIND_END))
		else $error("status on a byte that cannot carry one");

	a_ignored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_kind == KIND_IGNORED) |->
		(payload_byte == 8'd0 && frame_command == 8'd0 && frame_length == 8'd0
		&& frame_status == STATUS_NONE))
		else $error("ignored byte carries frame fields");
`endif

endmodule

/* rtl/core/fud_frame_ctl.sv */
// Frame tracking state and per-beat byte classification with running CRC-8.
// Depends on fud_pkg.
module fud_frame_ctl import fud_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  max_payload,
	output fud_result_t res
);

	logic       in_frame_q, in_frame_n;
	logic [8:0] pos_q, pos_n;
	logic [7:0] len_q, len_n;
	logic [7:0] cmd_q, cmd_n;
	logic [7:0] crc_q, crc_n;
	logic [7:0] rcv_q, rcv_n;
	logic [9:0] pos_w;
	logic [9:0] chk_pos;
	logic [7:0] crc_upd;

	assign pos_w   = {1'b0, pos_q};
	assign chk_pos = 10'd2 + {2'b00, len_q};
	assign crc_upd = crc8_update(crc_q, rx_byte);

	always_comb begin
		in_frame_n = in_frame_q;
		pos_n      = pos_q;
		len_n      = len_q;
		cmd_n      = cmd_q;
		crc_n      = crc_q;
		rcv_n      = rcv_q;
		res        = '0;
		res.kind   = KIND_IGNORED;
		res.status = STATUS_NONE;
		if (!in_frame_q) begin
			if (rx_byte == SOF_BYTE) begin
				in_frame_n = 1'b1;
				pos_n      = '0;
				len_n      = '0;
				cmd_n      = '0;
				crc_n      = '0;
				rcv_n      = '0;
				res.kind   = KIND_START;
			end
		end else begin
			if (pos_q == 9'd0) begin
				res.kind = KIND_LENGTH;
				len_n    = rx_byte;
				if (rx_byte > max_payload) begin
					res.status = STATUS_TOO_LONG;
					in_frame_n = 1'b0;
					pos_n      = '0;
				end else begin
					pos_n = 9'd1;
				end
			end else if (pos_q == 9'd1) begin
				res.kind = KIND_COMMAND;
				cmd_n    = rx_byte;
				crc_n    = crc_upd;
				pos_n    = 9'd2;
			end else if (pos_w < chk_pos) begin
				res.kind   = KIND_PAYLOAD;
				res.pbyte  = rx_byte;
				res.pindex = pos_q[7:0] - 8'd2;
				crc_n      = crc_upd;
				pos_n      = pos_q + 9'd1;
			end else if (pos_w == chk_pos) begin
				res.kind = KIND_CHECK;
				rcv_n    = rx_byte;
				pos_n    = pos_q + 9'd1;
			end else begin
				res.kind = KIND_END;
				if (rx_byte != EOF_BYTE) begin
					res.status = STATUS_BAD_END;
				end else if (crc_q == rcv_q) begin
					res.status = STATUS_GOOD;
				end else begin
					res.status = STATUS_MISMATCH;
				end
				in_frame_n = 1'b0;
				pos_n      = '0;
			end
			res.cmd = cmd_n;
			res.len = len_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			cmd_q      <= '0;
			crc_q      <= '0;
			rcv_q      <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_n;
			pos_q      <= pos_n;
			len_q      <= len_n;
			cmd_q      <= cmd_n;
			crc_q      <= crc_n;
			rcv_q      <= rcv_n;
		end
	end

endmodule

/* bench/tb_framed_uart_rx_deframer_crc8_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for framed_uart_rx_deframer_crc8_unit: directed frames, then random
// good, corrupted, oversized and broken frames over several max_payload settings.
// Depends on fud_pkg and the deframer RTL; holds its own deframer/CRC-8 predictor.
module tb_framed_uart_rx_deframer_crc8_unit;
	import fud_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 400;
	localparam int PHASE_BEATS    = 260;

	typedef struct {
		logic [7:0]  rx;
		bit          has_want;
		fud_result_t want;
	} dir_row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_stall = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [2:0] byte_kind;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [2:0] frame_status;
	logic [7:0] frame_command;
	logic [7:0] frame_length;

	// predictor state
	bit         in_frame_q;
	logic [8:0] frame_pos;
	logic [7:0] frame_len;
	logic [7:0] frame_cmd;
	logic [7:0] crc_run;
	logic [7:0] crc_rx;
	logic [7:0] max_len;

	fud_result_t exp_results[$];
	fud_result_t head;
	int          mismatch_cnt = 0;
	int          frame_beats  = 0;
	int          gapless_left = 0;
	int          idle_cycles  = 0;
	int          stall_left   = 0;
	int          free_left    = 0;
	int          stall_pick;
	bit          long_hold_go   = 1'b0;
	bit          long_hold_done = 1'b0;
	dir_row_t    dir_rows[25];
	logic [7:0]  phase_max[5];

	framed_uart_rx_deframer_crc8_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_kind    (byte_kind),
		.payload_byte (payload_byte),
		.payload_index(payload_index),
		.frame_status (frame_status),
		.frame_command(frame_command),
		.frame_length (frame_length)
	);

	always #4 clk = ~clk;

	// serial form of CRC-8 poly 0x07, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[7] ^ d[i];
			c  = {c[6:0], 1'b0};
			if (fb) begin
				c = c ^ 8'h07;
			end
		end
		return c;
	endfunction

	function automatic fud_result_t deframe_byte(input logic [7:0] b);
		fud_result_t r;
		r = '0;
		if (!in_frame_q) begin
			if (b == SOF_BYTE) begin
				in_frame_q = 1'b1;
				frame_pos  = '0;
				frame_len  = '0;
				frame_cmd  = '0;
				crc_run    = '0;
				crc_rx     = '0;
				r.kind     = KIND_START;
			end
			return r;
		end
		if (frame_pos == 0) begin
			r.kind    = KIND_LENGTH;
			frame_len = b;
			if (b > max_len) begin
				r.status   = STATUS_TOO_LONG;
				in_frame_q = 1'b0;
			end else begin
				frame_pos = 9'd1;
			end
		end else if (frame_pos == 1) begin
			r.kind    = KIND_COMMAND;
			frame_cmd = b;
			crc_run   = crc8_step(crc_run, b);
			frame_pos = 9'd2;
		end else if (frame_pos < 2 + frame_len) begin
			r.kind    = KIND_PAYLOAD;
			r.pbyte   = b;
			r.pindex  = 8'(frame_pos - 9'd2);
			crc_run   = crc8_step(crc_run, b);
			frame_pos = frame_pos + 9'd1;
		end else if (frame_pos == 2 + frame_len) begin
			r.kind    = KIND_CHECK;
			crc_rx    = b;
			frame_pos = frame_pos + 9'd1;
		end else begin
			r.kind = KIND_END;
			if (b != EOF_BYTE) begin
				r.status = STATUS_BAD_END;
			end else if (crc_run == crc_rx) begin
				r.status = STATUS_GOOD;
			end else begin
				r.status = STATUS_MISMATCH;
			end
			in_frame_q = 1'b0;
			frame_pos  = '0;
		end
		r.cmd = frame_cmd;
		r.len = frame_len;
		return r;
	endfunction

	function automatic fud_result_t exp_of(input byte_kind_t k, input frame_status_t s,
			input logic [7:0] c, input logic [7:0] l);
		fud_result_t r;
		r        = '0;
		r.kind   = k;
		r.status = s;
		r.cmd    = c;
		r.len    = l;
		return r;
	endfunction

	function automatic int next_send_gap();
		int r;
		if (gapless_left > 0) begin
			gapless_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			gapless_left = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	task automatic drive_beat(input logic [7:0] b, input bit has_want = 1'b0,
			input fud_result_t fixed = '0);
		int          gap;
		fud_result_t pred;
		gap = next_send_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		pred = deframe_byte(b);
		if (pred.kind != KIND_IGNORED) frame_beats++;
		exp_results.push_back(has_want ? fixed : pred);
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic set_max_payload(input logic [7:0] v);
		in_valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		max_len = v;
	endtask

	task automatic send_frame(input int n, input logic [7:0] c, input bit crc_bad,
			input bit end_bad);
		logic [7:0] crc;
		logic [7:0] d;
		logic [7:0] e;
		crc = crc8_step(8'h00, c);
		drive_beat(SOF_BYTE);
		drive_beat(n[7:0]);
		drive_beat(c);
		repeat (n) begin
			d   = 8'($urandom);
			crc = crc8_step(crc, d);
			drive_beat(d);
		end
		if (crc_bad) crc = crc ^ 8'($urandom_range(1, 255));
		drive_beat(crc);
		e = EOF_BYTE;
		if (end_bad) begin
			while (e == EOF_BYTE) e = 8'($urandom);
		end
		drive_beat(e);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (exp_results.size() == 0) begin
				$error("result beat with nothing expected: byte_kind %0d", byte_kind);
				mismatch_cnt++;
			end else begin
				head = exp_results.pop_front();
				check_field("byte_kind", byte_kind, head.kind);
				check_field("payload_byte", payload_byte, head.pbyte);
				check_field("payload_index", payload_index, head.pindex);
				check_field("frame_status", frame_status, head.status);
				check_field("frame_command", frame_command, head.cmd);
				check_field("frame_length", frame_length, head.len);
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (free_left != 0) begin
			free_left <= free_left - 1;
			out_stall <= 1'b0;
		end else if (long_hold_go && !long_hold_done) begin
			long_hold_done <= 1'b1;
			stall_left     <= LONG_HOLD;
			out_stall      <= 1'b1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 35) begin
				free_left <= $urandom_range(1, 40);
				out_stall <= 1'b0;
			end else if (stall_pick < 85) begin
				stall_left <= $urandom_range(0, 2);
				out_stall  <= 1'b1;
			end else if (stall_pick < 97) begin
				stall_left <= $urandom_range(3, 12);
				out_stall  <= 1'b1;
			end else begin
				stall_left <= $urandom_range(20, 60);
				out_stall  <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int p;
		int pick;
		int n;
		int phase_end;

		in_frame_q = 1'b0;
		frame_pos  = '0;
		frame_len  = '0;
		frame_cmd  = '0;
		crc_run    = '0;
		crc_rx     = '0;
		max_len    = MAX_PAYLOAD_RESET;

		dir_rows = '{
			'{8'h00, 1'b1, exp_of(KIND_IGNORED, STATUS_NONE,     8'h00, 8'h00)},
			'{8'hAA, 1'b1, exp_of(KIND_START,   STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_LENGTH,  STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_COMMAND, STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_CHECK,   STATUS_NONE,     8'h00, 8'h00)},
			'{8'h55, 1'b1, exp_of(KIND_END,     STATUS_GOOD,     8'h00, 8'h00)},
			// two-byte payload, good check
			'{8'hAA, 1'b0, '0},
			'{8'h02, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'hFF, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'hBC, 1'b0, '0},
			'{8'h55, 1'b0, '0},
			// start byte as command, check mismatch
			'{8'hAA, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'hAA, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h55, 1'b0, '0},
			'{8'hAA, 1'b1, exp_of(KIND_START,   STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_LENGTH,  STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_COMMAND, STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_CHECK,   STATUS_NONE,     8'h00, 8'h00)},
			'{8'h00, 1'b1, exp_of(KIND_END,     STATUS_BAD_END,  8'h00, 8'h00)},
			'{8'hAA, 1'b1, exp_of(KIND_START,   STATUS_NONE,     8'h00, 8'h00)},
			'{8'h81, 1'b1, exp_of(KIND_LENGTH,  STATUS_TOO_LONG, 8'h00, 8'h81)}
		};
		phase_max = '{8'd128, 8'd0, 8'd255, 8'd5, 8'($urandom_range(1, 254))};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			drive_beat(dir_rows[i].rx, dir_rows[i].has_want, dir_rows[i].want);
		end

		for (p = 0; p < 5; p++) begin
			set_max_payload(phase_max[p]);
			if (p == 1) long_hold_go <= 1'b1;
			phase_end = frame_beats + PHASE_BEATS;
			send_frame(max_len, 8'($urandom), 1'b0, 1'b0);
			while (frame_beats < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 80 || (pick < 90 && max_len == 8'hFF)) begin
					n = $urandom_range(0, 99);
					if (n < 70) begin
						n = $urandom_range(0, (max_len < 6) ? max_len : 6);
					end else if (n < 92) begin
						n = $urandom_range(0, (max_len < 32) ? max_len : 32);
					end else begin
						n = max_len;
					end
					send_frame(n, 8'($urandom), $urandom_range(0, 99) < 12,
						$urandom_range(0, 99) < 8);
				end else if (pick < 90) begin
					drive_beat(SOF_BYTE);
					drive_beat(8'($urandom_range(max_len + 1, 255)));
				end else if (pick < 95) begin
					repeat ($urandom_range(1, 4)) drive_beat(8'($urandom));
				end else begin
					// frame cut short, next bytes land inside it
					drive_beat(SOF_BYTE);
					repeat ($urandom_range(0, 3)) drive_beat(8'($urandom));
				end
			end
		end

		in_valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
